// ===== design/cocc_pkg.sv =====
// Package: shared types and constants for the capsule collision checker.
`timescale 1ns / 1ps
package cocc_pkg;

  localparam int MAX_CIRCLES = 16;
  localparam int MAX_LINES   = 16;
  localparam int FRAC_BITS   = 16;
  localparam int EPS_LSB     = 1;

  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int WIDE_W = 192;

  localparam logic [WIDE_W-1:0] EPS_AREA = WIDE_W'(EPS_LSB) << FRAC_BITS;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [1:0] {
    REQ_CHECK = 2'd0,
    REQ_LOAD_CIRCLE = 2'd1,
    REQ_LOAD_LINE = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_WORLD = 2'd1,
    CAUSE_CIRCLE = 2'd2,
    CAUSE_LINE = 2'd3
  } cause_t;

  typedef enum logic [1:0] {
    CFG_WORLD_W = 2'd0,
    CFG_WORLD_H = 2'd1,
    CFG_CIRCLES = 2'd2,
    CFG_LINES = 2'd3
  } cfg_idx_t;

  // Arithmetic unit opcodes.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    wide_t   a;
    wide_t   b;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BOUNDS,
    ST_OBJ,
    ST_SEG,
    ST_PN_SETUP,
    ST_PN_DD,
    ST_PN_DD2,
    ST_PN_DP,
    ST_PN_DP2,
    ST_PN_WW,
    ST_PN_WW2,
    ST_PN_BB,
    ST_PN_BB2,
    ST_PN_C1,
    ST_PN_C2,
    ST_PN_CC,
    ST_PN_TD,
    ST_PN_FIN,
    ST_CR_1,
    ST_CR_2,
    ST_CR_3,
    ST_CR_4,
    ST_CR_5,
    ST_CR_6,
    ST_CR_FIN,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage

// ===== design/cocc_alu.sv =====
// Shared arithmetic unit: one signed multiply (32x32 partial products) or add/sub per request.
`timescale 1ns / 1ps
module cocc_alu
  import cocc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  input  alu_req_t req,
  output logic     done,
  output wide_t    res
);

  // Multiply walks 6x6 limbs of 32 bits, one partial product per cycle.
  localparam int LIMBS = WIDE_W / 32;
  localparam int LW    = $clog2(LIMBS);

  logic           busy_r, busy_nxt;
  logic [LW-1:0]  i_r, i_nxt, j_r, j_nxt;
  wide_t          a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic           done_r, done_nxt;
  logic [63:0]    pp;
  logic [31:0]    la, lb;

  assign la = a_r[i_r*32 +: 32];
  assign lb = b_r[j_r*32 +: 32];
  assign pp = {32'd0, la} * {32'd0, lb};

  always_comb begin
    busy_nxt = busy_r;
    i_nxt = i_r;
    j_nxt = j_r;
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    done_nxt = 1'b0;
    if (!busy_r && req_valid) begin
      unique case (req.op)
        OP_ADD: begin
          acc_nxt = req.a + req.b;
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          acc_nxt = req.a - req.b;
          done_nxt = 1'b1;
        end
        default: begin
          a_nxt = req.a;
          b_nxt = req.b;
          acc_nxt = '0;
          i_nxt = '0;
          j_nxt = '0;
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      if ((32'(i_r) + 32'(j_r)) < LIMBS)
        acc_nxt = acc_r + (wide_t'(pp) << ((32'(i_r) + 32'(j_r)) * 32));
      if (j_r == LW'(LIMBS - 1)) begin
        j_nxt = '0;
        if (i_r == LW'(LIMBS - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

  a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r || $past(busy_r))
    else $error("alu done while busy without prior busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || !busy_r)
    else $error("alu done overlaps new multiply");
  a_mul_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && req_valid && req.op == OP_MUL) |=> busy_r)
    else $error("multiply did not start");

endmodule

// ===== design/capsule_obstacle_collision_check.sv =====
// Top level: capsule checker sequencer, obstacle store and sticky arm flag.
`timescale 1ns / 1ps
// Loads and ignored requests pass through ST_LOAD and ST_DONE before the result strobe.
// A check runs the bound test, then per active obstacle a chain of shared-unit steps;
// a multiply step issues its operands, walks the limb partial products and hands back
// the result, and a line runs more steps than a circle.
// Throughput: one transaction at a time; busy falls as the result strobe rises.
// Reset (rst_n, synchronous): control, sticky flag, config to defaults; no result stall.
module capsule_obstacle_collision_check
  import cocc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_x0,
  input  logic signed [31:0] in_y0,
  input  logic signed [31:0] in_x1,
  input  logic signed [31:0] in_y1,
  input  logic [30:0]        in_extent,
  input  logic               in_arm_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  output logic               out_hit,
  output logic [1:0]         out_hit_cause,
  output logic [3:0]         out_hit_index,
  output logic               out_arm_hit,
  output logic               out_arm_done
);

  // Configuration registers.
  logic [30:0] world_w_r, world_h_r;
  logic [CNT_W-1:0] ncirc_r, nline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_w_r <= 31'd67108864;
      world_h_r <= 31'd67108864;
      ncirc_r <= '0;
      nline_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WORLD_W: world_w_r <= cfg_data;
        CFG_WORLD_H: world_h_r <= cfg_data;
        CFG_CIRCLES: ncirc_r <= cfg_data[CNT_W-1:0];
        CFG_LINES:   nline_r <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // Obstacle stores (one write port, one registered read port each).
  logic signed [31:0] c_cx_m [MAX_CIRCLES];
  logic signed [31:0] c_cy_m [MAX_CIRCLES];
  logic [30:0]        c_r_m  [MAX_CIRCLES];
  logic signed [31:0] l_ax_m [MAX_LINES];
  logic signed [31:0] l_ay_m [MAX_LINES];
  logic signed [31:0] l_bx_m [MAX_LINES];
  logic signed [31:0] l_by_m [MAX_LINES];
  logic [30:0]        l_hw_m [MAX_LINES];

  // Latched transaction.
  req_t               typ_r;
  logic [3:0]         slot_r;
  logic signed [31:0] x0_r, y0_r, x1_r, y1_r;
  logic [30:0]        ext_r;
  logic               last_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             is_line_r, is_line_nxt;
  logic [2:0]       sub_r, sub_nxt;  // which of the five line tests
  logic             hit_r, hit_nxt;
  cause_t           cause_r, cause_nxt;
  logic [3:0]       hidx_r, hidx_nxt;
  logic             sticky_r, sticky_nxt;
  logic             ov_r, ov_nxt;

  // Obstacle read data registered.
  logic signed [31:0] oa_x_r, oa_y_r, ob_x_r, ob_y_r;
  logic [30:0]        orad_r;

  // Point-near operands: point p, segment a-b, threshold.
  wide_t px_r, py_r, ax_r, ay_r, bx_r, by_r, thr_r;
  wide_t px_nxt, py_nxt, ax_nxt, ay_nxt, bx_nxt, by_nxt, thr_nxt;
  // Scratch registers.
  wide_t t2_r, dd_r, dp_r, v0_r, v1_r;
  wide_t t2_nxt, dd_nxt, dp_nxt, v0_nxt, v1_nxt;

  logic     alu_go;
  alu_req_t alu_rq;
  logic     alu_done;
  wide_t    alu_res;
  logic     alu_wait_r, alu_wait_nxt;

  cocc_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req_valid(alu_go), .req(alu_rq),
    .done(alu_done), .res(alu_res)
  );

  function automatic wide_t sx(input logic signed [31:0] v);
    return wide_t'(v);
  endfunction

  logic [SLOT_W-1:0] rd_idx;
  assign rd_idx = idx_r[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      if (typ_r == REQ_LOAD_CIRCLE) begin
        c_cx_m[slot_r] <= x0_r;
        c_cy_m[slot_r] <= y0_r;
        c_r_m[slot_r] <= ext_r;
      end else if (typ_r == REQ_LOAD_LINE) begin
        l_ax_m[slot_r] <= x0_r;
        l_ay_m[slot_r] <= y0_r;
        l_bx_m[slot_r] <= x1_r;
        l_by_m[slot_r] <= y1_r;
        l_hw_m[slot_r] <= {1'b0, ext_r[30:1]};
      end
    end
    if (is_line_r) begin
      oa_x_r <= l_ax_m[rd_idx];
      oa_y_r <= l_ay_m[rd_idx];
      ob_x_r <= l_bx_m[rd_idx];
      ob_y_r <= l_by_m[rd_idx];
      orad_r <= l_hw_m[rd_idx];
    end else begin
      oa_x_r <= c_cx_m[rd_idx];
      oa_y_r <= c_cy_m[rd_idx];
      ob_x_r <= '0;
      ob_y_r <= '0;
      orad_r <= c_r_m[rd_idx];
    end
  end

  // Bound test: plain compares in 34-bit signed.
  logic signed [33:0] mnx, mxx, mny, mxy, e34, ww34, wh34;
  logic               bound_hit;
  always_comb begin
    mnx = (x0_r < x1_r) ? 34'(x0_r) : 34'(x1_r);
    mxx = (x0_r > x1_r) ? 34'(x0_r) : 34'(x1_r);
    mny = (y0_r < y1_r) ? 34'(y0_r) : 34'(y1_r);
    mxy = (y0_r > y1_r) ? 34'(y0_r) : 34'(y1_r);
    e34 = 34'(ext_r);
    ww34 = 34'(world_w_r) - e34;
    wh34 = 34'(world_h_r) - e34;
    bound_hit = (mnx < e34) || (mxx > ww34) || (mny < e34) || (mxy > wh34);
  end

  logic [CNT_W-1:0] nc_sat, nl_sat;
  assign nc_sat = (ncirc_r > CNT_W'(MAX_CIRCLES)) ? CNT_W'(MAX_CIRCLES) : ncirc_r;
  assign nl_sat = (nline_r > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES) : nline_r;

  // Threshold of current obstacle.
  logic signed [33:0] thr34;
  assign thr34 = 34'(orad_r) + 34'(ext_r) - 34'(EPS_LSB);

  logic neg_res;
  assign neg_res = alu_res[WIDE_W-1];

  // A multi-op step: issue once, then wait for done.
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    is_line_nxt = is_line_r;
    sub_nxt = sub_r;
    hit_nxt = hit_r;
    cause_nxt = cause_r;
    hidx_nxt = hidx_r;
    sticky_nxt = sticky_r;
    ov_nxt = 1'b0;
    px_nxt = px_r; py_nxt = py_r; ax_nxt = ax_r; ay_nxt = ay_r;
    bx_nxt = bx_r; by_nxt = by_r; thr_nxt = thr_r;
    t2_nxt = t2_r; dd_nxt = dd_r; dp_nxt = dp_r; v0_nxt = v0_r; v1_nxt = v1_r;
    alu_go = 1'b0;
    alu_rq = '{op: OP_ADD, a: '0, b: '0};
    alu_wait_nxt = alu_wait_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          hit_nxt = 1'b0;
          cause_nxt = CAUSE_NONE;
          hidx_nxt = '0;
          unique case (in_req_type)
            REQ_CHECK: state_nxt = ST_BOUNDS;
            default: state_nxt = ST_LOAD;
          endcase
        end
      end
      ST_LOAD: state_nxt = ST_DONE;
      ST_BOUNDS: begin
        idx_nxt = '0;
        is_line_nxt = 1'b0;
        if (bound_hit) begin
          hit_nxt = 1'b1;
          cause_nxt = CAUSE_WORLD;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_OBJ;
        end
      end
      ST_OBJ: begin
        // Obstacle read is in flight this cycle.
        if (!is_line_r && idx_r >= nc_sat) begin
          is_line_nxt = 1'b1;
          idx_nxt = '0;
        end else if (is_line_r && idx_r >= nl_sat) begin
          state_nxt = ST_DONE;
        end else begin
          sub_nxt = '0;
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        // Read data valid: choose the test.
        thr_nxt = wide_t'(thr34);
        if (thr34 <= 0) begin
          state_nxt = ST_NEXT;
        end else if (!is_line_r) begin
          px_nxt = sx(oa_x_r); py_nxt = sx(oa_y_r);
          ax_nxt = sx(x0_r); ay_nxt = sx(y0_r);
          bx_nxt = sx(x1_r); by_nxt = sx(y1_r);
          state_nxt = ST_PN_SETUP;
        end else begin
          unique case (sub_r)
            3'd0: begin
              state_nxt = ST_CR_1;
            end
            3'd1: begin
              px_nxt = sx(x0_r); py_nxt = sx(y0_r);
              ax_nxt = sx(oa_x_r); ay_nxt = sx(oa_y_r);
              bx_nxt = sx(ob_x_r); by_nxt = sx(ob_y_r);
              state_nxt = ST_PN_SETUP;
            end
            3'd2: begin
              px_nxt = sx(x1_r); py_nxt = sx(y1_r);
              ax_nxt = sx(oa_x_r); ay_nxt = sx(oa_y_r);
              bx_nxt = sx(ob_x_r); by_nxt = sx(ob_y_r);
              state_nxt = ST_PN_SETUP;
            end
            3'd3: begin
              px_nxt = sx(oa_x_r); py_nxt = sx(oa_y_r);
              ax_nxt = sx(x0_r); ay_nxt = sx(y0_r);
              bx_nxt = sx(x1_r); by_nxt = sx(y1_r);
              state_nxt = ST_PN_SETUP;
            end
            3'd4: begin
              px_nxt = sx(ob_x_r); py_nxt = sx(ob_y_r);
              ax_nxt = sx(x0_r); ay_nxt = sx(y0_r);
              bx_nxt = sx(x1_r); by_nxt = sx(y1_r);
              state_nxt = ST_PN_SETUP;
            end
            default: state_nxt = ST_NEXT;
          endcase
        end
        alu_wait_nxt = 1'b0;
      end

      // ---- point near: vectors d = b-a (v0,v1 hold dx,dy after setup) ----
      ST_PN_SETUP: begin
        // t2 = thr*thr
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: thr_r, b: thr_r};
          alu_wait_nxt = 1'b1;
          // Differences are narrow; done directly.
          v0_nxt = bx_r - ax_r;          // dx
          v1_nxt = by_r - ay_r;          // dy
          px_nxt = px_r - ax_r;          // wx
          py_nxt = py_r - ay_r;          // wy
          bx_nxt = px_r - bx_r;          // p - b
          by_nxt = py_r - by_r;
        end else if (alu_done) begin
          t2_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_DD;
        end
      end
      ST_PN_DD: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: v0_r, b: v0_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dd_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_DD2;
        end
      end
      ST_PN_DD2: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: v1_r, b: v1_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dd_nxt = dd_r + alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_DP;
        end
      end
      ST_PN_DP: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: px_r, b: v0_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dp_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_DP2;
        end
      end
      ST_PN_DP2: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: py_r, b: v1_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dp_nxt = dp_r + alu_res; alu_wait_nxt = 1'b0;
          // Degenerate or before a: distance to a. Past b: distance to b.
          if (!($signed(EPS_AREA) < dd_r) || !($signed(wide_t'(0)) < dp_r + alu_res))
            state_nxt = ST_PN_WW;
          else if (!(dp_r + alu_res < dd_r))
            state_nxt = ST_PN_BB;
          else
            state_nxt = ST_PN_C1;
        end
      end
      ST_PN_WW: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: px_r, b: px_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_WW2;
        end
      end
      ST_PN_WW2: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: py_r, b: py_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = v0_r + alu_res; v1_nxt = t2_r;
          alu_wait_nxt = 1'b0; state_nxt = ST_PN_FIN;
        end
      end
      ST_PN_BB: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: bx_r, b: bx_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_BB2;
        end
      end
      ST_PN_BB2: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: by_r, b: by_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = v0_r + alu_res; v1_nxt = t2_r;
          alu_wait_nxt = 1'b0; state_nxt = ST_PN_FIN;
        end
      end
      ST_PN_C1: begin
        // cross = wx*dy - wy*dx; dp reused as scratch
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: px_r, b: v1_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dp_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_C2;
        end
      end
      ST_PN_C2: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: py_r, b: v0_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dp_nxt = dp_r - alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_CC;
        end
      end
      ST_PN_CC: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: dp_r, b: dp_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_TD;
        end
      end
      ST_PN_TD: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: t2_r, b: dd_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v1_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_PN_FIN;
        end
      end
      ST_PN_FIN: begin
        // hit when v0 < v1
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_SUB, a: v0_r, b: v1_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          alu_wait_nxt = 1'b0;
          if (neg_res) begin
            hit_nxt = 1'b1;
            cause_nxt = is_line_r ? CAUSE_LINE : CAUSE_CIRCLE;
            hidx_nxt = idx_r[3:0];
            state_nxt = ST_DONE;
          end else if (is_line_r && sub_r != 3'd4) begin
            sub_nxt = sub_r + 3'd1;
            state_nxt = ST_SEG;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end

      // ---- crossing: r = p1-p0, s = b-a, q = a-p0 ----
      ST_CR_1: begin
        // den = rx*sy - ry*sx; operands set up here
        if (!alu_wait_r) begin
          px_nxt = sx(x1_r) - sx(x0_r);           // rx
          py_nxt = sx(y1_r) - sx(y0_r);           // ry
          ax_nxt = sx(ob_x_r) - sx(oa_x_r);       // sx
          ay_nxt = sx(ob_y_r) - sx(oa_y_r);       // sy
          bx_nxt = sx(oa_x_r) - sx(x0_r);         // qx
          by_nxt = sx(oa_y_r) - sx(y0_r);         // qy
          alu_go = 1'b1;
          alu_rq = '{op: OP_MUL, a: sx(x1_r) - sx(x0_r), b: sx(ob_y_r) - sx(oa_y_r)};
          alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dd_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_CR_2;
        end
      end
      ST_CR_2: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: py_r, b: ax_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          dd_nxt = dd_r - alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_CR_3;
        end
      end
      ST_CR_3: begin
        // tn = qx*sy - qy*sx
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: bx_r, b: ay_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_CR_4;
        end
      end
      ST_CR_4: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: by_r, b: ax_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v0_nxt = v0_r - alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_CR_5;
        end
      end
      ST_CR_5: begin
        // un = qx*ry - qy*rx
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: bx_r, b: py_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v1_nxt = alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_CR_6;
        end
      end
      ST_CR_6: begin
        if (!alu_wait_r) begin
          alu_go = 1'b1; alu_rq = '{op: OP_MUL, a: by_r, b: px_r}; alu_wait_nxt = 1'b1;
        end else if (alu_done) begin
          v1_nxt = v1_r - alu_res; alu_wait_nxt = 1'b0; state_nxt = ST_CR_FIN;
        end
      end
      ST_CR_FIN: begin
        // Normalize sign of den, then range tests.
        if (dd_r[WIDE_W-1]) begin
          dd_nxt = -dd_r; v0_nxt = -v0_r; v1_nxt = -v1_r;
        end else if (($signed(EPS_AREA) < dd_r) && !v0_r[WIDE_W-1] && !(dd_r < v0_r) &&
                     !v1_r[WIDE_W-1] && !(dd_r < v1_r)) begin
          hit_nxt = 1'b1;
          cause_nxt = CAUSE_LINE;
          hidx_nxt = idx_r[3:0];
          state_nxt = ST_DONE;
        end else begin
          sub_nxt = 3'd1;
          state_nxt = ST_SEG;
        end
      end

      ST_NEXT: begin
        idx_nxt = idx_r + 1'b1;
        state_nxt = ST_OBJ;
      end
      ST_DONE: begin
        ov_nxt = 1'b1;
        if (typ_r == REQ_CHECK) begin
          sticky_nxt = 1'b0;
          if (!last_r) sticky_nxt = sticky_r | hit_r;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sticky_r <= 1'b0;
      ov_r <= 1'b0;
      alu_wait_r <= 1'b0;
      is_line_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      sticky_r <= sticky_nxt;
      ov_r <= ov_nxt;
      alu_wait_r <= alu_wait_nxt;
      is_line_r <= is_line_nxt;
      idx_r <= idx_nxt;
    end
    if (state_r == ST_IDLE && start) begin
      typ_r <= req_t'(in_req_type);
      slot_r <= in_slot;
      x0_r <= in_x0; y0_r <= in_y0; x1_r <= in_x1; y1_r <= in_y1;
      ext_r <= in_extent;
      last_r <= in_arm_last;
    end
    sub_r <= sub_nxt;
    hit_r <= hit_nxt;
    cause_r <= cause_nxt;
    hidx_r <= hidx_nxt;
    px_r <= px_nxt; py_r <= py_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; thr_r <= thr_nxt;
    t2_r <= t2_nxt; dd_r <= dd_nxt; dp_r <= dp_nxt; v0_r <= v0_nxt; v1_r <= v1_nxt;
    // Result registers.
    if (state_r == ST_DONE) begin
      out_hit <= hit_r;
      out_hit_cause <= cause_r;
      out_hit_index <= hidx_r;
      out_arm_hit <= (typ_r == REQ_CHECK) ? (sticky_r | hit_r) : sticky_r;
      out_arm_done <= (typ_r == REQ_CHECK) ? last_r : 1'b0;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = ov_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("start not taken");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_arm_done && out_hit_cause == CAUSE_NONE) |-> !out_hit)
    else $error("hit without cause");
  a_sticky_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_arm_done) |=> !sticky_r)
    else $error("sticky flag not cleared after arm end");

endmodule
